// ===== design/sst_pkg.sv =====
// Shared types, character codes and token kinds for the source tokenizer.
// Used by the tokenizer top level; has no dependencies of its own.
package sst_pkg;

  // scanner mode between bytes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_WORD,
    MODE_OP,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_ERROR
  } lex_mode_e;

  // token kind codes as seen on the result channel
  typedef enum logic [4:0] {
    KIND_EOF      = 5'd0,
    KIND_INT      = 5'd1,
    KIND_IDENT    = 5'd2,
    KIND_IF       = 5'd3,
    KIND_OUT      = 5'd4,
    KIND_ASSIGN   = 5'd5,
    KIND_EQ       = 5'd6,
    KIND_NE       = 5'd7,
    KIND_LT       = 5'd8,
    KIND_LE       = 5'd9,
    KIND_GT       = 5'd10,
    KIND_GE       = 5'd11,
    KIND_PLUS     = 5'd12,
    KIND_MINUS    = 5'd13,
    KIND_STAR     = 5'd14,
    KIND_SLASH    = 5'd15,
    KIND_SEMI     = 5'd16,
    KIND_LPAREN   = 5'd17,
    KIND_RPAREN   = 5'd18,
    KIND_LBRACE   = 5'd19,
    KIND_RBRACE   = 5'd20,
    KIND_BAD_CHAR = 5'd21,
    KIND_BAD_BANG = 5'd22
  } kind_e;

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // keyword prefixes, first byte in the upper lanes
  localparam logic [23:0] KW_IF  = 24'h006966;
  localparam logic [23:0] KW_OUT = 24'h6F7574;

  // one result entry
  typedef struct packed {
    kind_e       kind;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [23:0] start_offset;
    logic [7:0]  text_length;
    logic [31:0] number_value;
    logic        number_overflow;
    logic        last;
  } result_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_op_start(logic [7:0] c);
    return (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) || (c == CH_BANG);
  endfunction

  // kind of a token that is complete after one byte
  function automatic kind_e single_kind(logic [7:0] c);
    kind_e k;
    unique case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h3B:   k = KIND_SEMI;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      default: k = KIND_BAD_CHAR;
    endcase
    return k;
  endfunction

  function automatic result_t make_result(kind_e k, logic [15:0] line, logic [15:0] col,
                                          logic [23:0] off, logic [7:0] len,
                                          logic [31:0] val, logic ovf);
    result_t r;
    r.kind            = k;
    r.start_line      = line;
    r.start_col       = col;
    r.start_offset    = off;
    r.text_length     = len;
    r.number_value    = val;
    r.number_overflow = ovf;
    r.last            = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/sst_src_if.sv =====
// Source byte channel of the tokenizer: valid/ready with cmd and ch.
// No dependencies.
interface sst_src_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink (input valid, input cmd, input ch, output ready);
endinterface

// ===== design/sst_tok_if.sv =====
// Token result channel of the tokenizer: valid/ready with the token fields.
// No dependencies.
interface sst_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [15:0] start_line;
  logic [15:0] start_col;
  logic [23:0] start_offset;
  logic [7:0]  text_length;
  logic [31:0] number_value;
  logic        number_overflow;
  logic        last;

  modport source (output valid, output kind, output start_line, output start_col,
                  output start_offset, output text_length, output number_value,
                  output number_overflow, output last, input ready);
  modport sink (input valid, input kind, input start_line, input start_col,
                input start_offset, input text_length, input number_value,
                input number_overflow, input last, output ready);
endinterface

// ===== design/script_source_tokenizer.sv =====
// Streaming source tokenizer: source bytes in, tokens with position out.
// Depends on sst_pkg, sst_src_if and sst_tok_if.
//
// One source byte (or the end marker) is taken per clock while the result
// queue holds two entries or fewer. Each item is held in an input register
// while the scanner state and up to two tokens are worked out, then the
// tokens land in a four-entry result queue that drives the output. The
// output drains one token per clock while the sink is ready; an item that
// closes one token and gives a one-byte token fills two entries, and the
// byte rate holds as long as the sink keeps up. After the end marker all
// position and scanner state is back at its reset values for the next
// source.
module script_source_tokenizer (
  input logic       clk_i,
  input logic       rst_ni,
  sst_src_if.sink   src_i,
  sst_tok_if.source tok_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // input register
  logic       stg_v_q;
  logic       stg_cmd_q;
  logic [7:0] stg_ch_q;
  logic       stg_fire;

  // scanner state
  sst_pkg::lex_mode_e mode_q, mode_d;
  logic [7:0]  pend_q, pend_d;
  logic [15:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [23:0] cur_off_q, cur_off_d;
  logic [15:0] tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic [23:0] tok_off_q, tok_off_d;
  logic [7:0]  len_q, len_d;
  logic [31:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;
  logic [23:0] prefix_q, prefix_d;

  // result queue
  sst_pkg::result_t q_mem [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;
  logic [1:0]       push_n;
  sst_pkg::result_t r0, r1;

  // input stage handshake
  assign stg_fire    = stg_v_q && (cnt_q <= QCntW'(QDepth - 2));
  assign src_i.ready = !stg_v_q || stg_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else if (src_i.ready) begin
      stg_v_q <= src_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_i.valid && src_i.ready) begin
      stg_cmd_q <= src_i.cmd;
      stg_ch_q  <= src_i.ch;
    end
  end

  // byte classes and position after this byte
  logic [7:0]  c;
  logic        c_digit, c_word_start, c_space;
  logic [15:0] adv_line, adv_col;
  logic [23:0] adv_off;

  assign c            = stg_ch_q;
  assign c_digit      = sst_pkg::is_digit(c);
  assign c_word_start = sst_pkg::is_alpha(c) || (c == sst_pkg::CH_UNDER);
  assign c_space      = sst_pkg::is_space(c);
  assign adv_off      = (cur_off_q == 24'hFFFFFF) ? cur_off_q : cur_off_q + 24'd1;
  assign adv_line     = (c != sst_pkg::CH_NL || cur_line_q == 16'hFFFF) ? cur_line_q
                                                                        : cur_line_q + 16'd1;
  assign adv_col      = (c == sst_pkg::CH_NL) ? 16'd1 :
                        (cur_col_q == 16'hFFFF) ? cur_col_q : cur_col_q + 16'd1;

  // decimal accumulate with saturation
  logic [35:0] acc_x10;
  logic [31:0] acc_next;
  logic        acc_sat;
  logic [7:0]  len_grow;

  assign acc_x10  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, c[3:0]};
  assign acc_sat  = (acc_x10[35:32] != 4'd0);
  assign acc_next = acc_sat ? 32'hFFFFFFFF : acc_x10[31:0];
  assign len_grow = (len_q == 8'hFF) ? len_q : len_q + 8'd1;

  // token closed by a pending mode
  logic             close_v;
  sst_pkg::result_t close_r;
  sst_pkg::kind_e   word_kind, op1_kind, op2_kind;

  always_comb begin
    word_kind = sst_pkg::KIND_IDENT;
    if (len_q == 8'd2 && prefix_q == sst_pkg::KW_IF) word_kind = sst_pkg::KIND_IF;
    if (len_q == 8'd3 && prefix_q == sst_pkg::KW_OUT) word_kind = sst_pkg::KIND_OUT;
    op1_kind = (pend_q == sst_pkg::CH_BANG) ? sst_pkg::KIND_BAD_BANG :
               (pend_q == sst_pkg::CH_EQ)   ? sst_pkg::KIND_ASSIGN :
               (pend_q == sst_pkg::CH_LT)   ? sst_pkg::KIND_LT : sst_pkg::KIND_GT;
    op2_kind = (pend_q == sst_pkg::CH_EQ)   ? sst_pkg::KIND_EQ :
               (pend_q == sst_pkg::CH_BANG) ? sst_pkg::KIND_NE :
               (pend_q == sst_pkg::CH_LT)   ? sst_pkg::KIND_LE : sst_pkg::KIND_GE;
    close_v = 1'b1;
    close_r = sst_pkg::make_result(op1_kind, tok_line_q, tok_col_q, tok_off_q, 8'd1,
                                   32'd0, 1'b0);
    unique case (mode_q)
      sst_pkg::MODE_NUM: begin
        close_r = sst_pkg::make_result(sst_pkg::KIND_INT, tok_line_q, tok_col_q,
                                       tok_off_q, len_q, acc_q, ovf_q);
      end
      sst_pkg::MODE_WORD: begin
        close_r = sst_pkg::make_result(word_kind, tok_line_q, tok_col_q, tok_off_q,
                                       len_q, 32'd0, 1'b0);
      end
      sst_pkg::MODE_OP: begin
        close_r.kind = op1_kind;
      end
      sst_pkg::MODE_SLASH: begin
        close_r.kind = sst_pkg::KIND_SLASH;
      end
      default: begin
        close_v = 1'b0;
      end
    endcase
  end

  // next scanner state and the results of this item
  logic             a_v, b_v;
  sst_pkg::result_t a_r, b_r;
  logic             do_close, do_fresh;
  sst_pkg::kind_e   fresh_kind;

  assign fresh_kind = sst_pkg::single_kind(c);

  always_comb begin
    mode_d     = mode_q;
    pend_d     = pend_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    cur_off_d  = cur_off_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_off_d  = tok_off_q;
    len_d      = len_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    prefix_d   = prefix_q;
    do_close   = 1'b0;
    do_fresh   = 1'b0;
    a_v        = 1'b0;
    b_v        = 1'b0;
    a_r        = close_r;
    b_r        = sst_pkg::make_result(fresh_kind, cur_line_q, cur_col_q, cur_off_q, 8'd1,
                                      32'd0, 1'b0);

    if (stg_fire && stg_cmd_q) begin
      // end marker: close pending, emit eof, back to reset values
      a_v        = close_v;
      b_v        = 1'b1;
      b_r        = sst_pkg::make_result(sst_pkg::KIND_EOF, cur_line_q, cur_col_q,
                                        cur_off_q, 8'd0, 32'd0, 1'b0);
      mode_d     = sst_pkg::MODE_IDLE;
      pend_d     = 8'd0;
      cur_line_d = 16'd1;
      cur_col_d  = 16'd1;
      cur_off_d  = 24'd0;
      tok_line_d = 16'd1;
      tok_col_d  = 16'd1;
      tok_off_d  = 24'd0;
      len_d      = 8'd0;
      acc_d      = 32'd0;
      ovf_d      = 1'b0;
      prefix_d   = 24'd0;
    end else if (stg_fire) begin
      cur_line_d = adv_line;
      cur_col_d  = adv_col;
      cur_off_d  = adv_off;
      unique case (mode_q)
        sst_pkg::MODE_NUM: begin
          if (c_digit) begin
            acc_d = acc_next;
            ovf_d = ovf_q | acc_sat;
            len_d = len_grow;
          end else begin
            do_close = 1'b1;
            do_fresh = 1'b1;
          end
        end
        sst_pkg::MODE_WORD: begin
          if (c_word_start || c_digit) begin
            if (len_q < 8'd3) prefix_d = {prefix_q[15:0], c};
            len_d = len_grow;
          end else begin
            do_close = 1'b1;
            do_fresh = 1'b1;
          end
        end
        sst_pkg::MODE_OP: begin
          if (c == sst_pkg::CH_EQ) begin
            a_v      = 1'b1;
            a_r.kind = op2_kind;
            a_r.text_length = 8'd2;
            mode_d   = sst_pkg::MODE_IDLE;
          end else if (pend_q == sst_pkg::CH_BANG) begin
            do_close = 1'b1;
            mode_d   = sst_pkg::MODE_ERROR;
          end else begin
            do_close = 1'b1;
            do_fresh = 1'b1;
          end
        end
        sst_pkg::MODE_SLASH: begin
          if (c == sst_pkg::CH_SLASH) begin
            mode_d = sst_pkg::MODE_COMMENT;
          end else begin
            do_close = 1'b1;
            do_fresh = 1'b1;
          end
        end
        sst_pkg::MODE_COMMENT: begin
          if (c == sst_pkg::CH_NL) mode_d = sst_pkg::MODE_IDLE;
        end
        sst_pkg::MODE_IDLE: begin
          do_fresh = 1'b1;
        end
        default: begin
        end
      endcase

      if (do_close) a_v = close_v;

      // a byte seen with nothing pending
      if (do_fresh) begin
        if (c_space) begin
          mode_d = sst_pkg::MODE_IDLE;
        end else begin
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
          tok_off_d  = cur_off_q;
          if (c_digit) begin
            mode_d = sst_pkg::MODE_NUM;
            acc_d  = {28'd0, c[3:0]};
            ovf_d  = 1'b0;
            len_d  = 8'd1;
          end else if (c_word_start) begin
            mode_d   = sst_pkg::MODE_WORD;
            prefix_d = {16'd0, c};
            len_d    = 8'd1;
          end else if (sst_pkg::is_op_start(c)) begin
            mode_d = sst_pkg::MODE_OP;
            pend_d = c;
          end else if (c == sst_pkg::CH_SLASH) begin
            mode_d = sst_pkg::MODE_SLASH;
          end else begin
            b_v    = 1'b1;
            mode_d = (fresh_kind == sst_pkg::KIND_BAD_CHAR) ? sst_pkg::MODE_ERROR
                                                            : sst_pkg::MODE_IDLE;
          end
        end
      end
    end
  end

  // order the results and mark the last one
  always_comb begin
    r0      = a_v ? a_r : b_r;
    r0.last = !(a_v && b_v);
    r1      = b_r;
    r1.last = 1'b1;
    push_n  = {1'b0, a_v} + {1'b0, b_v};
  end

  // scanner state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sst_pkg::MODE_IDLE;
      pend_q     <= 8'd0;
      cur_line_q <= 16'd1;
      cur_col_q  <= 16'd1;
      cur_off_q  <= 24'd0;
      tok_line_q <= 16'd1;
      tok_col_q  <= 16'd1;
      tok_off_q  <= 24'd0;
      len_q      <= 8'd0;
      acc_q      <= 32'd0;
      ovf_q      <= 1'b0;
      prefix_q   <= 24'd0;
    end else begin
      mode_q     <= mode_d;
      pend_q     <= pend_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      cur_off_q  <= cur_off_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_off_q  <= tok_off_d;
      len_q      <= len_d;
      acc_q      <= acc_d;
      ovf_q      <= ovf_d;
      prefix_q   <= prefix_d;
    end
  end

  // result queue pointers and fill count
  assign pop = tok_o.valid && tok_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_n);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + QCntW'(push_n) - QCntW'(pop);
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) q_mem[wr_q] <= r0;
    if (push_n == 2'd2) q_mem[wr_q + QPtrW'(1)] <= r1;
  end

  // output channel
  assign tok_o.valid           = (cnt_q != '0);
  assign tok_o.kind            = q_mem[rd_q].kind;
  assign tok_o.start_line      = q_mem[rd_q].start_line;
  assign tok_o.start_col       = q_mem[rd_q].start_col;
  assign tok_o.start_offset    = q_mem[rd_q].start_offset;
  assign tok_o.text_length     = q_mem[rd_q].text_length;
  assign tok_o.number_value    = q_mem[rd_q].number_value;
  assign tok_o.number_overflow = q_mem[rd_q].number_overflow;
  assign tok_o.last            = q_mem[rd_q].last;

`ifndef NO_ASSERTIONS
  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue over capacity");

  // a byte in error mode gives no token
  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_fire && !stg_cmd_q && mode_q == sst_pkg::MODE_ERROR) |-> push_n == 2'd0)
    else $error("token emitted in error mode");

  // end marker always gives an eof and returns to the start position
  a_eof_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_fire && stg_cmd_q) |=> (mode_q == sst_pkg::MODE_IDLE && cur_line_q == 16'd1
                                 && cur_off_q == 24'd0))
    else $error("state not cleared after end marker");

  // of two tokens from one item only the second is marked last
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> (!r0.last && r1.last))
    else $error("last flag misplaced on paired tokens");
`endif

endmodule
